// File: hw/rtl/upss_pkg.sv
// ----------------------------------------------------------------------------
// upss_pkg
// Shared types, character constants and per-byte splitter functions for the
// URI path segment splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package upss_pkg;

   localparam logic [7:0] PCT_CHAR   = 8'h25;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [7:0] NUL_CHAR   = 8'h00;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
   localparam int unsigned MAX_FEEDS   = 3;

   // one result item
   typedef struct packed {
      logic [7:0] seg_byte;
      logic       byte_valid;
      logic       seg_last;
      logic       path_done;
   } rsp_type;

   // segment splitter state
   typedef struct packed {
      logic [7:0] held_byte;
      logic       held_valid;
      logic       dot_pending;
      logic       after_slash;
      logic       segment_open;
      logic       truncated;
   } split_type;

   typedef struct packed {
      split_type st;
      logic      emit;
      rsp_type   rsp;
   } step_type;

   function automatic logic hex_ok(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      begin
         if (c <= 8'h39) v = c - 8'h30;
         else if (c >= 8'h61) v = c - 8'h57;
         else v = c - 8'h37;
         return v[3:0];
      end
   endfunction

   function automatic split_type split_clear(input logic trunc);
      split_type s;
      begin
         s = '0;
         s.truncated = trunc;
         return s;
      end
   endfunction

   // end of path: always one result with path_done
   function automatic step_type finish_fn(input split_type s);
      step_type t;
      begin
         t.emit = 1'b1;
         if (s.dot_pending) t.rsp = '{DOT_CHAR, 1'b1, 1'b1, 1'b1};
         else if (s.held_valid) t.rsp = '{s.held_byte, 1'b1, 1'b1, 1'b1};
         else t.rsp = '{NUL_CHAR, 1'b0, 1'b0, 1'b1};
         t.st = split_clear(s.truncated);
         return t;
      end
   endfunction

   // one decoded byte into the splitter
   function automatic step_type feed_fn(input split_type s, input logic [7:0] c);
      step_type t;
      begin
         t.st   = s;
         t.emit = 1'b0;
         t.rsp  = '0;
         if (!s.truncated) begin
            if (c == NUL_CHAR) begin
               t = finish_fn(s);
               t.st.truncated = 1'b1;
            end else if (c == SLASH_CHAR) begin
               if (s.held_valid) begin
                  t.emit = 1'b1;
                  t.rsp  = '{s.held_byte, 1'b1, 1'b1, 1'b0};
               end
               t.st.held_valid   = 1'b0;
               t.st.dot_pending  = 1'b0;
               t.st.segment_open = 1'b0;
               t.st.after_slash  = 1'b1;
            end else if (s.dot_pending) begin
               t.emit = 1'b1;
               t.rsp  = '{DOT_CHAR, 1'b1, 1'b0, 1'b0};
               t.st.dot_pending = 1'b0;
               t.st.held_byte   = c;
               t.st.held_valid  = 1'b1;
            end else if (!s.segment_open && s.after_slash && (c == DOT_CHAR)) begin
               t.st.dot_pending  = 1'b1;
               t.st.segment_open = 1'b1;
            end else begin
               if (s.held_valid) begin
                  t.emit = 1'b1;
                  t.rsp  = '{s.held_byte, 1'b1, 1'b0, 1'b0};
               end
               t.st.held_byte    = c;
               t.st.held_valid   = 1'b1;
               t.st.segment_open = 1'b1;
            end
         end
         return t;
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/uri_path_segment_splitter.sv
// ----------------------------------------------------------------------------
// uri_path_segment_splitter
// Percent-decodes a URI path byte stream and emits its non-empty segments
// byte by byte, dropping single-dot segments between slashes.
//
//   channel  ports                                   direction
//   req      req_valid/req_ready, path_byte/last     in
//   rsp      rsp_valid/rsp_ready, segment fields     out
//
// One raw byte is decoded and split in the cycle it is accepted; its 0 to 4
// result items land in a 4-entry result buffer, one item leaves per cycle while rsp_ready is high.
// A new byte is taken when the buffer is empty or its last item is leaving,
// so bytes giving at most one item stream at one per cycle while rsp_ready is high.
// Synchronous active-high reset empties the buffer and clears all path state.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_path_segment_splitter
   import upss_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_path_byte,
   input  wire logic       req_path_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_seg_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_seg_last,
   output logic            rsp_path_done,
   output logic            rsp_run_last
);

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_PCT,
      ESC_DIG
   } esc_type;

   esc_type                ec_ff, ec_in;
   logic [7:0]             dig_ff, dig_in;
   split_type              sp_ff, sp_in;
   rsp_type                buf_ff [MAX_RESULTS];
   rsp_type                res_in [MAX_RESULTS];
   logic [RES_CNT_W-1:0]   rem_ff, n_in;
   logic [RES_IDX_W-1:0]   pos_ff;

   logic [7:0]             fb [MAX_FEEDS];
   logic                   fv [MAX_FEEDS];
   logic [1:0]             nf;
   step_type               t;
   logic                   req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign req_ready = (rem_ff == '0) || ((rem_ff == RES_CNT_W'(1)) && rsp_ready);

   // percent decoder: up to three decoded bytes per raw byte
   always_comb begin
      ec_in  = ec_ff;
      dig_in = dig_ff;
      nf     = 2'd0;
      for (int i = 0; i < MAX_FEEDS; i++) begin
         fb[i] = NUL_CHAR;
         fv[i] = 1'b0;
      end
      if (!sp_ff.truncated) begin
         unique case (ec_ff)
            ESC_NONE: begin
               if (req_path_byte == PCT_CHAR) begin
                  ec_in = ESC_PCT;
               end else begin
                  fb[nf] = req_path_byte; fv[nf] = 1'b1; nf = nf + 2'd1;
               end
            end
            ESC_PCT: begin
               if (hex_ok(req_path_byte)) begin
                  dig_in = req_path_byte;
                  ec_in  = ESC_DIG;
               end else begin
                  fb[nf] = PCT_CHAR; fv[nf] = 1'b1; nf = nf + 2'd1;
                  if (req_path_byte == PCT_CHAR) begin
                     ec_in = ESC_PCT;
                  end else begin
                     ec_in = ESC_NONE;
                     fb[nf] = req_path_byte; fv[nf] = 1'b1; nf = nf + 2'd1;
                  end
               end
            end
            ESC_DIG: begin
               if (hex_ok(req_path_byte) && hex_ok(dig_ff)) begin
                  ec_in = ESC_NONE;
                  fb[nf] = {hex_val(dig_ff), hex_val(req_path_byte)};
                  fv[nf] = 1'b1; nf = nf + 2'd1;
               end else begin
                  fb[nf] = PCT_CHAR; fv[nf] = 1'b1; nf = nf + 2'd1;
                  fb[nf] = dig_ff;   fv[nf] = 1'b1; nf = nf + 2'd1;
                  if (req_path_byte == PCT_CHAR) begin
                     ec_in = ESC_PCT;
                  end else begin
                     ec_in = ESC_NONE;
                     fb[nf] = req_path_byte; fv[nf] = 1'b1; nf = nf + 2'd1;
                  end
               end
            end
            default: begin
               ec_in = ESC_NONE;
            end
         endcase
         if (req_path_last) begin
            if (ec_in == ESC_PCT) begin
               fb[nf] = PCT_CHAR; fv[nf] = 1'b1; nf = nf + 2'd1;
            end else if (ec_in == ESC_DIG) begin
               fb[nf] = PCT_CHAR; fv[nf] = 1'b1; nf = nf + 2'd1;
               fb[nf] = dig_in;   fv[nf] = 1'b1; nf = nf + 2'd1;
            end
         end
      end
      if (req_path_last) begin
         ec_in  = ESC_NONE;
         dig_in = NUL_CHAR;
      end
   end

   // segment splitter over the decoded bytes, then end of path
   always_comb begin
      sp_in = sp_ff;
      n_in  = '0;
      t     = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_in[i] = '0;
      end
      for (int i = 0; i < MAX_FEEDS; i++) begin
         if (fv[i]) begin
            t     = feed_fn(sp_in, fb[i]);
            sp_in = t.st;
            if (t.emit) begin
               res_in[n_in[RES_IDX_W-1:0]] = t.rsp;
               n_in = n_in + RES_CNT_W'(1);
            end
         end
      end
      if (req_path_last && !sp_in.truncated) begin
         t = finish_fn(sp_in);
         res_in[n_in[RES_IDX_W-1:0]] = t.rsp;
         n_in  = n_in + RES_CNT_W'(1);
      end
      if (req_path_last) begin
         sp_in = split_clear(1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ec_ff  <= ESC_NONE;
         dig_ff <= NUL_CHAR;
         sp_ff  <= split_clear(1'b0);
         rem_ff <= '0;
         pos_ff <= '0;
      end else begin
         if (req_take) begin
            ec_ff  <= ec_in;
            dig_ff <= dig_in;
            sp_ff  <= sp_in;
            rem_ff <= n_in;
            pos_ff <= '0;
            for (int i = 0; i < MAX_RESULTS; i++) begin
               buf_ff[i] <= res_in[i];
            end
         end else if (rsp_take) begin
            rem_ff <= rem_ff - RES_CNT_W'(1);
            pos_ff <= pos_ff + RES_IDX_W'(1);
         end
      end
   end

   assign rsp_valid      = (rem_ff != '0);
   assign rsp_seg_byte   = buf_ff[pos_ff].seg_byte;
   assign rsp_byte_valid = buf_ff[pos_ff].byte_valid;
   assign rsp_seg_last   = buf_ff[pos_ff].seg_last;
   assign rsp_path_done  = buf_ff[pos_ff].path_done;
   assign rsp_run_last   = (rem_ff == RES_CNT_W'(1));

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("result buffer count out of range");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_done |-> rsp_run_last)
      else $error("path_done item is not the last of its byte");

   a_seg_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_seg_last || !rsp_byte_valid) |->
         rsp_byte_valid || (rsp_seg_byte == NUL_CHAR))
      else $error("empty item carries segment data");

   a_trunc_no_esc: assert property (@(posedge clock) disable iff (reset)
      sp_ff.truncated |-> (ec_ff == ESC_NONE))
      else $error("escape pending on a truncated path");

endmodule

`default_nettype wire
